@@ rtl/pfmw_pkg.sv @@
// pfmw_pkg: types, constants and helpers for the windowed pulse flow meter
// used by pulse_flow_meter_window and pfmw_div; no dependencies

package pfmw_pkg;

  // field widths fixed by the interface
  localparam int NOW_W   = 32;
  localparam int PCNT_W  = 16;
  localparam int PER_W   = 16;
  localparam int CFG_W   = 32;
  localparam int TOT_W   = 32;
  localparam int OUT_W   = 48;

  // parameter defaults
  localparam int COUNTER_BITS_DEF = 16;
  localparam int DIV_DW_DEF       = 64;
  localparam int DIV_VW_DEF       = 32;

  // register reset values
  localparam logic [PER_W-1:0] PERIOD_RST = 16'd1000;
  localparam logic [CFG_W-1:0] PPL_RST    = 32'd29491200;  // 450.0 in q16.16
  localparam logic [CFG_W-1:0] HZ_RST     = 32'd491520;    // 7.5 in q16.16

  typedef enum logic [1:0] {
    CFG_SAMPLE_PERIOD   = 2'd0,
    CFG_PULSES_PER_LITER = 2'd1,
    CFG_HZ_PER_LPM      = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_GO1,
    S_WAIT1,
    S_GO2,
    S_WAIT2,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [NOW_W-1:0]  now_ms;
    logic [PCNT_W-1:0] pulse_count;
  } in_item_t;

  typedef struct packed {
    logic [OUT_W-1:0] freq_hz_q16;
    logic [OUT_W-1:0] flow_lpm_q16;
    logic [OUT_W-1:0] total_liters_q16;
  } out_item_t;

  // clamp a 64-bit quotient to the 48-bit output range
  function automatic logic [OUT_W-1:0] sat48(input logic [63:0] v);
    logic [OUT_W-1:0] r;
    r = (|v[63:OUT_W]) ? '1 : v[OUT_W-1:0];
    return r;
  endfunction

endpackage

@@ rtl/pfmw_div.sv @@
// pfmw_div: bit-serial restoring divider, one quotient bit per cycle
// depends on pfmw_pkg for parameter defaults

module pfmw_div
  import pfmw_pkg::*;
#(
  parameter int DW = DIV_DW_DEF,
  parameter int VW = DIV_VW_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CW = $clog2(DW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DW-1:0] dvd;   // dividend bits shift out, quotient bits shift in
  logic [VW-1:0] rem;
  logic [VW-1:0] dvs;
  logic [VW:0]   rem_sh;
  logic [VW:0]   diff;
  logic          ge;

  assign rem_sh   = {rem, dvd[DW-1]};
  assign diff     = rem_sh - {1'b0, dvs};
  assign ge       = !diff[VW];
  assign quotient = dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      if (start) begin
        busy <= 1'b1;
        done <= 1'b0;
      end else if (busy && cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        done <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt <= CW'(DW);
      dvd <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (busy) begin
      cnt <= cnt - CW'(1);
      dvd <= {dvd[DW-2:0], ge};
      rem <= ge ? diff[VW-1:0] : rem_sh[VW-1:0];
    end
  end

endmodule

@@ rtl/pulse_flow_meter_window.sv @@
// pulse_flow_meter_window: windowed pulse-counting flow meter, top level
// depends on pfmw_pkg and pfmw_div

// Each input transaction carries the millisecond time and a free-running pulse
// counter. When the time since the window mark reaches sample_period_ms the mark
// moves on by that period, the counter difference is added to a 32-bit wrapping
// pulse total, and one output transaction follows with frequency, flow and total
// volume in unsigned q.16, each clamped at 48 bits; otherwise the transaction
// produces nothing and leaves the block idle. A transaction that closes a window
// is worked through in steps: states S_MUL1 and S_MUL2 form delta*1000, then the
// bit-serial dividers run, where the shared 64-bit divider is used twice in a row (first
// for the total volume, in parallel with the frequency division, then for the
// flow, which needs the finished frequency). A new input transaction is taken as
// soon as the result is in the output register, even if it is not yet taken.
// Configuration writes are applied at once and must only be made while idle.

module pulse_flow_meter_window
  import pfmw_pkg::*;
#(
  parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int CB  = COUNTER_BITS;
  localparam int PW  = CB + 10;      // delta*1000 fits in 10 more bits
  localparam int FDW = PW + 16;      // frequency dividend, q.16 shift
  localparam int BDW = 64;           // total and flow dividends
  localparam int BVW = 32;

  // configuration registers
  logic [PER_W-1:0] sample_period_ms;
  logic [CFG_W-1:0] pulses_per_liter_q16;
  logic [CFG_W-1:0] hz_per_lpm_q16;

  // window state
  logic [CB-1:0]    last_count;
  logic [TOT_W-1:0] pulse_total;
  logic [NOW_W-1:0] window_mark_ms;

  // working registers
  state_t           state, state_next;
  logic [CB-1:0]    delta;
  logic [PW-1:0]    prod;
  logic [OUT_W-1:0] freq_r;
  logic [OUT_W-1:0] total_r;
  logic             fdone, tdone;

  // datapath for the input transaction
  logic             in_acc;
  logic [NOW_W-1:0] elapsed;
  logic             window_hit;
  logic [CB-1:0]    cnt_in;
  logic [CB-1:0]    cnt_diff;

  // divider hookup
  logic             div_a_start, div_a_done;
  logic [FDW-1:0]   div_a_q;
  logic             div_b_start, div_b_done;
  logic [BDW-1:0]   div_b_dividend;
  logic [BVW-1:0]   div_b_divisor;
  logic [BDW-1:0]   div_b_q;
  logic             both_done;
  logic             out_free;
  logic [OUT_W-1:0] flow_val;

  assign in_acc     = in_valid && in_ready;
  assign elapsed    = in_data.now_ms - window_mark_ms;     // modulo 2^32
  assign window_hit = !(elapsed < NOW_W'(sample_period_ms));
  assign cnt_in     = CB'(in_data.pulse_count);            // upper counter bits dropped
  assign cnt_diff   = cnt_in - last_count;                 // wraps at the counter width
  assign both_done  = (fdone || div_a_done) && (tdone || div_b_done);
  assign out_free   = !out_valid || out_ready;
  assign flow_val   = (hz_per_lpm_q16 == '0) ? '0 : sat48(div_b_q);

  // first run of divider b is the total volume, second run the flow
  assign div_b_dividend = (state == S_GO1) ? {pulse_total, 32'b0} : {freq_r, 16'b0};
  assign div_b_divisor  = (state == S_GO1) ? pulses_per_liter_q16 : hz_per_lpm_q16;

  // frequency: delta*1000*2^16 / period, one bit per cycle
  pfmw_div #(
    .DW(FDW),
    .VW(PER_W)
  ) u_div_freq (
    .clk      (clk),
    .rst      (rst),
    .start    (div_a_start),
    .dividend ({prod, 16'b0}),
    .divisor  (sample_period_ms),
    .done     (div_a_done),
    .quotient (div_a_q)
  );

  // shared divider for total volume and flow
  pfmw_div #(
    .DW(BDW),
    .VW(BVW)
  ) u_div_main (
    .clk      (clk),
    .rst      (rst),
    .start    (div_b_start),
    .dividend (div_b_dividend),
    .divisor  (div_b_divisor),
    .done     (div_b_done),
    .quotient (div_b_q)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_valid && window_hit) state_next = S_MUL1;
      S_MUL1:  state_next = S_MUL2;
      S_MUL2:  state_next = S_GO1;
      S_GO1:   state_next = S_WAIT1;
      S_WAIT1: if (both_done) state_next = S_GO2;
      S_GO2:   state_next = S_WAIT2;
      S_WAIT2: if (div_b_done) state_next = S_OUT;
      S_OUT:   if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready    = 1'b0;
    div_a_start = 1'b0;
    div_b_start = 1'b0;
    case (state)
      S_IDLE:  in_ready = 1'b1;
      S_GO1: begin
        div_a_start = 1'b1;
        div_b_start = 1'b1;
      end
      S_GO2:   div_b_start = 1'b1;
      default: ;
    endcase
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state                <= S_IDLE;
      sample_period_ms     <= PERIOD_RST;
      pulses_per_liter_q16 <= PPL_RST;
      hz_per_lpm_q16       <= HZ_RST;
      last_count           <= '0;
      pulse_total          <= '0;
      window_mark_ms       <= '0;
      fdone                <= 1'b0;
      tdone                <= 1'b0;
      out_valid            <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        case (cfg_index)
          CFG_SAMPLE_PERIOD:    sample_period_ms     <= cfg_data[PER_W-1:0];
          CFG_PULSES_PER_LITER: pulses_per_liter_q16 <= cfg_data;
          CFG_HZ_PER_LPM:       hz_per_lpm_q16       <= cfg_data;
          default: ;
        endcase
      end

      // window closes: advance mark, fold the counter difference into the total
      if (in_acc && window_hit) begin
        window_mark_ms <= window_mark_ms + NOW_W'(sample_period_ms);
        last_count     <= cnt_in;
        pulse_total    <= pulse_total + TOT_W'(cnt_diff);
      end

      if (state == S_GO1) begin
        fdone <= 1'b0;
        tdone <= 1'b0;
      end else begin
        if (div_a_done) fdone <= 1'b1;
        if (div_b_done) tdone <= 1'b1;
      end

      if (state == S_OUT && out_free) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc && window_hit) delta <= cnt_diff;
    // delta*1000 as delta*1024 - delta*32 + delta*8 over states S_MUL1 and S_MUL2
    if (state == S_MUL1) prod <= (PW'(delta) << 10) - (PW'(delta) << 5);
    if (state == S_MUL2) prod <= prod + (PW'(delta) << 3);
    if (state == S_WAIT1 && both_done) begin
      freq_r  <= (sample_period_ms == '0) ? '0 : sat48(64'(div_a_q));
      total_r <= (pulses_per_liter_q16 == '0) ? '0 : sat48(div_b_q);
    end
    if (state == S_OUT && out_free) begin
      out_data.freq_hz_q16      <= freq_r;
      out_data.flow_lpm_q16     <= flow_val;
      out_data.total_liters_q16 <= total_r;
    end
  end

  // window state moves only with an accepted input transaction
  a_total_hold: assert property (@(posedge clk) disable iff (rst)
    !in_acc |=> $stable(pulse_total))
    else $error("pulse total changed without an input transaction");

  a_mark_hold: assert property (@(posedge clk) disable iff (rst)
    !in_acc |=> $stable(window_mark_ms))
    else $error("window mark changed without an input transaction");

  // the frequency divider only finishes while its result is awaited
  a_freq_done: assert property (@(posedge clk) disable iff (rst)
    div_a_done |-> state == S_WAIT1)
    else $error("frequency divider finished outside its wait state");

  // a waiting result is never overwritten by the next one
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("pending result overwritten");

endmodule

@@ tb/pulse_flow_meter_window_tb.sv @@
// pulse_flow_meter_window_tb: self-checking bench for the windowed pulse flow meter
// depends on pfmw_pkg and pulse_flow_meter_window; predicts every window result
// in-bench and checks it field by field across several register settings

`timescale 1ns / 1ps

module pulse_flow_meter_window_tb;
  import pfmw_pkg::*;

  // clock, reset and block ports; the bench-driven ones are known from time zero
  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  in_item_t         in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_item_t        out_data;
  logic             cfg_we = 1'b0;
  logic [1:0]       cfg_index = CFG_SAMPLE_PERIOD;
  logic [CFG_W-1:0] cfg_data = '0;

  pulse_flow_meter_window dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // samples waiting for the driver, window results waiting for the monitor
  in_item_t  pending_samples[$];
  out_item_t window_results[$];

  // idle rates of the two sides, changed only between phases
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  // bench copy of the registers and of the meter state
  bit [15:0] period_ms_m = PERIOD_RST;
  bit [31:0] ppl_q16_m   = PPL_RST;
  bit [31:0] hz_q16_m    = HZ_RST;
  bit [15:0] last_cnt_m;
  bit [31:0] pulse_sum_m;
  bit [31:0] mark_ms_m;

  // stimulus generator's own view of time, window mark and counter
  bit [31:0] gen_time;
  bit [31:0] gen_mark;
  bit [15:0] gen_cnt;

  int unsigned mismatches = 0;
  int unsigned samples_taken = 0;
  int unsigned results_checked = 0;
  int unsigned settings_used = 1;

  initial begin
    forever #2 clk = ~clk;
  end

  // generous hard stop, far above the slowest legal run
  initial begin
    #10ms;
    $display("timeout with %0d results still pending", window_results.size());
    $display("pulse_flow_meter_window_tb failed");
    $finish;
  end

  task automatic report_mismatch(input string what);
    if (mismatches < 40) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
    mismatches++;
  endtask

  function automatic bit [47:0] clamp48(input bit [63:0] v);
    return (v > 64'h0000_FFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : v[47:0];
  endfunction

  // advance the meter on one sample; a closed window queues one expected result
  task automatic meter_step(input in_item_t s);
    bit [31:0] elapsed;
    bit [15:0] delta;
    bit [63:0] scaled;
    out_item_t r;
    elapsed = s.now_ms - mark_ms_m;
    if (elapsed < {16'h0, period_ms_m}) begin
      return;
    end
    mark_ms_m   = mark_ms_m + {16'h0, period_ms_m};
    delta       = s.pulse_count - last_cnt_m;
    last_cnt_m  = s.pulse_count;
    pulse_sum_m = pulse_sum_m + {16'h0, delta};
    // pulses per window scaled to hertz in q.16
    scaled = (64'(delta) * 64'd1000) << 16;
    r.freq_hz_q16 = (period_ms_m != 0) ? clamp48(scaled / 64'(period_ms_m)) : '0;
    // flow uses the already clamped frequency
    r.flow_lpm_q16 = (hz_q16_m != 0) ?
                     clamp48({r.freq_hz_q16, 16'h0} / 64'(hz_q16_m)) : '0;
    r.total_liters_q16 = (ppl_q16_m != 0) ?
                         clamp48({pulse_sum_m, 32'h0} / 64'(ppl_q16_m)) : '0;
    window_results.push_back(r);
  endtask

  // driver: one transaction per handshake, valid held until taken
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        meter_step(in_data);
        samples_taken++;
      end
      if (!in_valid || in_ready) begin
        if (pending_samples.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= pending_samples.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (window_results.size() == 0) begin
          report_mismatch($sformatf("result with no window pending: %h", out_data));
        end else begin
          out_item_t e;
          e = window_results.pop_front();
          results_checked++;
          if (out_data.freq_hz_q16 !== e.freq_hz_q16)
            report_mismatch($sformatf("freq_hz_q16 %h, predicted %h",
                                      out_data.freq_hz_q16, e.freq_hz_q16));
          if (out_data.flow_lpm_q16 !== e.flow_lpm_q16)
            report_mismatch($sformatf("flow_lpm_q16 %h, predicted %h",
                                      out_data.flow_lpm_q16, e.flow_lpm_q16));
          if (out_data.total_liters_q16 !== e.total_liters_q16)
            report_mismatch($sformatf("total_liters_q16 %h, predicted %h",
                                      out_data.total_liters_q16, e.total_liters_q16));
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic add_sample(input bit [31:0] now, input bit [15:0] cnt);
    pending_samples.push_back(in_item_t'{now_ms: now, pulse_count: cnt});
  endtask

  // wait until every sample is taken and every result checked, then let a
  // window's worth of divider latency pass so the block is surely idle
  task automatic wait_drained();
    while (pending_samples.size() != 0 || in_valid || window_results.size() != 0)
      @(negedge clk);
    repeat (200) @(posedge clk);
  endtask

  // write all three registers back to back, block idle
  task automatic load_settings(input bit [15:0] per, input bit [31:0] ppl,
                               input bit [31:0] hz);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SAMPLE_PERIOD;
    cfg_data  <= {16'h0, per};
    @(posedge clk);
    cfg_index <= CFG_PULSES_PER_LITER;
    cfg_data  <= ppl;
    @(posedge clk);
    cfg_index <= CFG_HZ_PER_LPM;
    cfg_data  <= hz;
    @(posedge clk);
    cfg_we <= 1'b0;
    period_ms_m = per;
    ppl_q16_m   = ppl;
    hz_q16_m    = hz;
    settings_used++;
  endtask

  // mostly a plausible meter: time moves forward by up to one window, the
  // counter climbs; some time jumps force catch-up windows, some samples carry
  // arbitrary time or counter values
  task automatic fill_random(input int n);
    bit [31:0] per;
    bit [31:0] now;
    bit [31:0] elapsed;
    int unsigned pick;
    per      = {16'h0, period_ms_m};
    gen_time = mark_ms_m;
    gen_mark = mark_ms_m;
    gen_cnt  = last_cnt_m;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        now = $urandom;
      end else begin
        if (pick < 15)
          gen_time = gen_time + per * $urandom_range(2, 6);
        else
          gen_time = gen_time + $urandom_range(0, per);
        now = gen_time;
      end
      if ($urandom_range(0, 9) == 0)
        gen_cnt = $urandom_range(0, 65535);
      else
        gen_cnt = gen_cnt + $urandom_range(0, 400);
      add_sample(now, gen_cnt);
      // keep the generator's time from falling behind the window mark
      elapsed = now - gen_mark;
      if (elapsed >= per)
        gen_mark = gen_mark + per;
      if ($signed(gen_time - gen_mark) < 0)
        gen_time = gen_mark;
    end
  endtask

  task automatic run_phase(input bit [15:0] per, input bit [31:0] ppl, input bit [31:0] hz,
                           input int unsigned s_idle, input int unsigned r_stall,
                           input int n);
    load_settings(per, ppl, hz);
    send_idle_pct  = s_idle;
    recv_stall_pct = r_stall;
    fill_random(n);
    wait_drained();
  endtask

  initial begin
    last_cnt_m  = '0;
    pulse_sum_m = '0;
    mark_ms_m   = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed part on reset settings: window edges, counter extremes and
    // wrap, time wrap and elapsed-time wrap past the mark
    add_sample(32'd0, 16'h0000);         // no window yet
    add_sample(32'd999, 16'd5);          // one ms short of a window
    add_sample(32'd1000, 16'd100);       // exactly one window
    add_sample(32'd1500, 16'hFFFF);      // mid window, counter at top
    add_sample(32'd2000, 16'hFFFF);      // large delta
    add_sample(32'd3000, 16'd3);         // counter wraps
    add_sample(32'hFFFF_FFFF, 16'h0000); // time far ahead, window closes
    add_sample(32'd3999, 16'h8000);      // just behind the mark, elapsed wraps
    add_sample(32'd5999, 16'h8000);      // no window
    add_sample(32'd6000, 16'h8000);      // window with zero pulses
    add_sample(32'h8000_0000, 16'h7FFF); // top time bit alone
    add_sample(32'h7FFF_FFFF, 16'h0001);
    add_sample(32'd9000, 16'h5555);
    add_sample(32'd9999, 16'hAAAA);
    wait_drained();

    // register extremes first, then ordinary and random settings
    run_phase(16'd1, 32'd1, 32'd1, 52, 0, 305);
    run_phase(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 52, 305);
    run_phase(16'd0, 32'd0, 32'd0, 22, 22, 305);
    run_phase(16'd250, $urandom, $urandom, 0, 0, 305);
    run_phase(16'd1000, PPL_RST, 32'd0, 52, 0, 305);
    run_phase(16'($urandom_range(1, 65535)), $urandom, 32'($urandom_range(1, 1000)),
              0, 52, 305);

    $display("%0d sample transactions over %0d register settings, %0d window results checked",
             samples_taken, settings_used, results_checked);
    if (mismatches == 0) begin
      $display("pulse_flow_meter_window_tb passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("pulse_flow_meter_window_tb failed");
    end
    $finish;
  end

endmodule
